### hdl/fisf_pkg.sv
`default_nettype none
package fisf_pkg;

    localparam logic [31:0] RSQRT_MAGIC      = 32'h5f3759df;
    localparam logic [31:0] F32_HALF         = 32'h3F000000;
    localparam logic [31:0] F32_THREE_HALVES = 32'h3FC00000;
    localparam logic [31:0] F32_DEFAULT_NAN  = 32'h7FC00000;
    localparam logic [31:0] F32_INF          = 32'h7F800000;
    localparam logic [31:0] F32_QUIET        = 32'h00400000;
    localparam int          PIPE_DEPTH       = 10;

    // Unrounded result of a float step, or a finished special value
    typedef struct packed {
        logic                special;
        logic [31:0]         bits;
        logic                sign;
        logic signed [10:0]  ex;
        logic [63:0]         sig;
    } unr_t;

    function automatic logic f_isnan(logic [31:0] a);
        return a[30:0] > F32_INF[30:0];
    endfunction

    function automatic logic f_isinf(logic [31:0] a);
        return a[30:0] == F32_INF[30:0];
    endfunction

    function automatic logic [23:0] f_mant(logic [31:0] a);
        return (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
    endfunction

    function automatic logic signed [10:0] f_exp(logic [31:0] a);
        return (a[30:23] == 8'd0) ? -11'sd149 : $signed({3'b000, a[30:23]}) - 11'sd150;
    endfunction

    // Round sig * 2^ex to nearest even and pack as binary32
    function automatic logic [31:0] round_pack(logic s, logic signed [10:0] ex,
                                               logic [63:0] sig);
        int          p;
        int          drop;
        int          alt;
        int          q;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        logic [31:0] packed_v;
        p = 0;
        for (int i = 1; i < 64; i++)
        begin
            if (sig[i])
                p = i;
        end
        drop = p - 23;
        alt  = -149 - int'(ex);
        if (alt > drop)
            drop = alt;
        if (drop <= 0)
            kept = sig << (-drop);
        else if (drop >= 64)
            kept = 64'd0;
        else
        begin
            rem  = sig & ((64'd1 << drop) - 64'd1);
            half = 64'd1 << (drop - 1);
            kept = sig >> drop;
            if (rem > half || (rem == half && kept[0]))
                kept = kept + 64'd1;
        end
        q = int'(ex) + drop;
        if (kept >= 64'h1000000)
        begin
            kept = kept >> 1;
            q    = q + 1;
        end
        packed_v = (32'(q + 149) << 23) + {8'd0, kept[23:0]};
        if (sig == 64'd0)
            return {s, 31'd0};
        else if (q + 150 >= 255)
            return {s, F32_INF[30:0]};
        else
            return {s, packed_v[30:0]};
    endfunction

    // Multiply front half: specials and the raw mantissa product
    function automatic unr_t mul_front(logic [31:0] a, logic [31:0] b);
        unr_t        r;
        logic        s;
        logic [23:0] ma;
        logic [23:0] mb;
        s         = a[31] ^ b[31];
        ma        = f_mant(a);
        mb        = f_mant(b);
        r.special = 1'b1;
        r.bits    = {s, 31'd0};
        r.sign    = s;
        r.ex      = f_exp(a) + f_exp(b);
        r.sig     = 64'(ma) * 64'(mb);
        if (f_isnan(a))
            r.bits = a | F32_QUIET;
        else if (f_isnan(b))
            r.bits = b | F32_QUIET;
        else if (f_isinf(a) || f_isinf(b))
        begin
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0)
                r.bits = F32_DEFAULT_NAN;
            else
                r.bits = {s, F32_INF[30:0]};
        end
        else if (ma != 24'd0 && mb != 24'd0)
            r.special = 1'b0;
        return r;
    endfunction

    // Subtract front half: align with sticky bit and add
    function automatic unr_t sub_front(logic [31:0] a, logic [31:0] b);
        unr_t               r;
        logic               sa;
        logic               sb;
        logic               ts;
        logic [23:0]        ma;
        logic [23:0]        mb;
        logic [23:0]        tm;
        logic signed [10:0] ea;
        logic signed [10:0] eb;
        logic signed [10:0] te;
        int                 d;
        logic [63:0]        big_a;
        logic [63:0]        big_b;
        logic [63:0]        sum;
        sa = a[31];
        sb = ~b[31];
        ma = f_mant(a);
        mb = f_mant(b);
        ea = f_exp(a);
        eb = f_exp(b);
        if (ea < eb || (ea == eb && ma < mb))
        begin
            tm = ma; ma = mb; mb = tm;
            te = ea; ea = eb; eb = te;
            ts = sa; sa = sb; sb = ts;
        end
        big_a = {16'd0, ma, 24'd0} << 14;
        big_b = {16'd0, mb, 24'd0} << 14;
        d     = int'(ea) - int'(eb);
        if (d >= 63)
            big_b = {63'd0, big_b != 64'd0};
        else
            big_b = (big_b >> d) | {63'd0, (big_b & ((64'd1 << d) - 64'd1)) != 64'd0};
        sum       = (sa == sb) ? big_a + big_b : big_a - big_b;
        r.special = 1'b1;
        r.bits    = 32'd0;
        r.sign    = sa;
        r.ex      = ea - 11'sd38;
        r.sig     = sum;
        if (f_isnan(a))
            r.bits = a | F32_QUIET;
        else if (f_isnan(b))
            r.bits = b | F32_QUIET;
        else if (f_isinf(a))
            r.bits = (f_isinf(b) && a[31] == b[31]) ? F32_DEFAULT_NAN : a;
        else if (f_isinf(b))
            r.bits = {~b[31], F32_INF[30:0]};
        else if (a[30:0] == 31'd0 && b[30:0] == 31'd0)
            r.bits = {a[31] & ~b[31], 31'd0};
        else if (sum != 64'd0)
            r.special = 1'b0;
        return r;
    endfunction

    function automatic logic [31:0] finish(unr_t r);
        return r.special ? r.bits : round_pack(r.sign, r.ex, r.sig);
    endfunction

endpackage
`default_nettype wire

### hdl/fast_inverse_sqrt_float_unit.sv
// Channel  | Handshake            | Payload
// input    | in_valid / in_ready  | operand_bits[31:0]
// output   | out_valid / out_ready| rsqrt_bits[31:0]
//
// Ten register stages: each float step takes two (operate, then normalise
// and round), the seed subtract rides in the first stage.
// One item per cycle while the output is not stalled.
// Reset clears the stage valid bits only.
// A stalled output freezes the whole pipe; in_ready drops with it.
`default_nettype none
module fast_inverse_sqrt_float_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] operand_bits,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      rsqrt_bits
);
    import fisf_pkg::*;

    logic [PIPE_DEPTH-1:0] v_reg;
    logic [31:0]           y0_reg [0:7];
    unr_t                  m1_reg, m2_reg, m3_reg, d_reg, m4_reg;
    logic [31:0]           x2_reg, t1_reg, t_reg, u_reg, y_reg;
    logic                  adv;

    // Advance whenever the last stage is empty or being taken
    assign adv       = ~v_reg[PIPE_DEPTH-1] | out_ready;
    assign in_ready  = adv;
    assign out_valid = v_reg[PIPE_DEPTH-1];
    assign rsqrt_bits = y_reg;

    // Move valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[PIPE_DEPTH-2:0], in_valid};
    end

    // Advance the data path
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            y0_reg[0] <= RSQRT_MAGIC - {operand_bits[31], operand_bits[31:1]};
            for (int i = 1; i < 8; i++)
                y0_reg[i] <= y0_reg[i-1];
            m1_reg <= mul_front(operand_bits, F32_HALF);
            x2_reg <= finish(m1_reg);
            m2_reg <= mul_front(x2_reg, y0_reg[1]);
            t1_reg <= finish(m2_reg);
            m3_reg <= mul_front(t1_reg, y0_reg[3]);
            t_reg  <= finish(m3_reg);
            d_reg  <= sub_front(F32_THREE_HALVES, t_reg);
            u_reg  <= finish(d_reg);
            m4_reg <= mul_front(y0_reg[7], u_reg);
            y_reg  <= finish(m4_reg);
        end
    end

endmodule
`default_nettype wire

### hdl/fisf_checker.sv
`default_nettype none
module fisf_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] rsqrt_bits
);
    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(rsqrt_bits))
        else $error("stalled result changed");

    // Empty output means the pipe is free to take an item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // Output stall freezes the intake
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("item taken while pipe stalled");

endmodule

bind fast_inverse_sqrt_float_unit fisf_checker u_fisf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .rsqrt_bits (rsqrt_bits)
);
`default_nettype wire
